@@ sv/mm_pkg.sv @@
// shared types and constants for the matrix multiply block
package mm_pkg;

  localparam int DIM_W       = 4;
  localparam int IDX_W       = 3;
  localparam int VAL_W       = 16;
  localparam int CELL_W      = 6;
  localparam int PROD_W      = 35;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_MULT,
    OP_ERR
  } op_code_t;

  typedef struct packed {
    op_code_t          code;
    logic [CELL_W-1:0] elem_addr;
    logic [VAL_W-1:0]  value;
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0] ar;
    logic [DIM_W-1:0] ac;
    logic [DIM_W-1:0] br;
    logic [DIM_W-1:0] bc;
  } dims_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_el;
    logic             err;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

endpackage

@@ sv/mm_in_if.sv @@
// input item channel of the matrix multiply block
interface mm_in_if;
  import mm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] element_value;

  modport source (
    output valid, command, row_index, col_index, element_value,
    input  ready
  );

  modport sink (
    input  valid, command, row_index, col_index, element_value,
    output ready
  );
endinterface

@@ sv/mm_out_if.sv @@
// result item channel of the matrix multiply block
interface mm_out_if;
  import mm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [PROD_W-1:0] product_value;
  logic                     last;
  logic                     size_error;

  modport source (
    output valid, out_row, out_col, product_value, last, size_error,
    input  ready
  );

  modport sink (
    input  valid, out_row, out_col, product_value, last, size_error,
    output ready
  );
endinterface

@@ sv/mm_front.sv @@
// front end: accepts input items, drops out-of-range loads, checks sizes
module mm_front #(
  parameter int MAX_DIM = 8
) (
  mm_in_if.sink          in_ch,
  input  mm_pkg::dims_t  dims,
  output logic           push,
  output mm_pkg::op_t    push_op,
  input  logic           push_ready
);
  import mm_pkg::*;

  logic [DIM_W-1:0] row_ext;
  logic [DIM_W-1:0] col_ext;
  logic             a_fit;
  logic             b_fit;
  logic             keep;

  assign row_ext = DIM_W'(in_ch.row_index);
  assign col_ext = DIM_W'(in_ch.col_index);
  assign a_fit   = (row_ext < dims.ar) && (col_ext < dims.ac);
  assign b_fit   = (row_ext < dims.br) && (col_ext < dims.bc);

  always_comb begin
    push_op.elem_addr = CELL_W'(int'(in_ch.row_index) * MAX_DIM + int'(in_ch.col_index));
    push_op.value     = in_ch.element_value;
    push_op.code      = OP_LOAD_A;
    keep              = 1'b0;
    case (in_ch.command)
      CMD_LOAD_A: begin
        push_op.code = OP_LOAD_A;
        keep         = a_fit;
      end
      CMD_LOAD_B: begin
        push_op.code = OP_LOAD_B;
        keep         = b_fit;
      end
      CMD_COMPUTE: begin
        push_op.code = (dims.ac == dims.br) ? OP_MULT : OP_ERR;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = push_ready;
  assign push        = in_ch.valid && push_ready && keep;

endmodule

@@ sv/mm_queue.sv @@
// short operation queue between front and back
module mm_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mm_pkg::op_t push_op,
  output logic        push_ready,
  output logic        pop_valid,
  output mm_pkg::op_t pop_op,
  input  logic        pop
);
  import mm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  op_t              entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic [PTR_W:0]   count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count_r != (PTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_op     = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ sv/mm_back.sv @@
// back end: element stores, multiply-accumulate sequencer and result register
module mm_back #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mm_pkg::dims_t dims,
  input  logic          op_valid,
  input  mm_pkg::op_t   op,
  output logic          op_pop,
  mm_out_if.source      out_ch
);
  import mm_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MUL_W = 2 * ELEM_WIDTH;

  logic [ELEM_WIDTH-1:0] a_mem [CELLS];
  logic [ELEM_WIDTH-1:0] b_mem [CELLS];

  seq_state_t state_r;
  seq_state_t state_nxt;
  logic [CW-1:0] i_r, j_r, k_r;
  logic [CW-1:0] i_nxt, j_nxt, k_nxt;

  logic                  stall;
  logic                  a_we;
  logic                  b_we;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         a_addr;
  logic [AW-1:0]         b_addr;
  logic [ELEM_WIDTH-1:0] wr_val;
  logic                  end_k;
  logic                  end_j;
  logic                  end_i;

  tag_t issue_tag;
  tag_t s1_tag_r;
  tag_t s2_tag_r;

  logic [ELEM_WIDTH-1:0]   a_rd_r;
  logic [ELEM_WIDTH-1:0]   b_rd_r;
  logic signed [MUL_W-1:0] prod_r;
  logic signed [63:0]      prod_ext;
  logic [PROD_W-1:0]       acc_r;
  logic [PROD_W-1:0]       acc_nxt;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_row_r;
  logic [IDX_W-1:0]  out_col_r;
  logic [PROD_W-1:0] out_value_r;
  logic              out_last_r;
  logic              out_err_r;

  assign stall   = out_valid_r && !out_ch.ready;
  assign wr_addr = op.elem_addr[AW-1:0];
  assign wr_val  = ELEM_WIDTH'($signed(op.value));
  assign a_addr  = AW'(int'(i_r) * MAX_DIM + int'(k_r));
  assign b_addr  = AW'(int'(k_r) * MAX_DIM + int'(j_r));
  assign end_k   = DIM_W'(k_r) == (dims.ac - 1'b1);
  assign end_j   = DIM_W'(j_r) == (dims.bc - 1'b1);
  assign end_i   = DIM_W'(i_r) == (dims.ar - 1'b1);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    op_pop    = 1'b0;
    a_we      = 1'b0;
    b_we      = 1'b0;
    issue_tag = '0;
    case (state_r)
      ST_IDLE: begin
        if (!stall && op_valid) begin
          op_pop = 1'b1;
          case (op.code)
            OP_LOAD_A: a_we = 1'b1;
            OP_LOAD_B: b_we = 1'b1;
            OP_MULT: begin
              state_nxt = ST_RUN;
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
            end
            OP_ERR: begin
              issue_tag.valid   = 1'b1;
              issue_tag.first   = 1'b1;
              issue_tag.last_k  = 1'b1;
              issue_tag.last_el = 1'b1;
              issue_tag.err     = 1'b1;
            end
            default: begin
              op_pop = 1'b1;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (!stall) begin
          issue_tag.valid   = 1'b1;
          issue_tag.first   = k_r == '0;
          issue_tag.last_k  = end_k;
          issue_tag.last_el = end_i && end_j;
          issue_tag.row     = IDX_W'(i_r);
          issue_tag.col     = IDX_W'(j_r);
          if (end_k) begin
            k_nxt = '0;
            if (end_j) begin
              j_nxt = '0;
              if (end_i) begin
                i_nxt     = '0;
                state_nxt = ST_IDLE;
              end else begin
                i_nxt = i_r + 1'b1;
              end
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // element stores
  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[wr_addr] <= wr_val;
    end
    if (b_we) begin
      b_mem[wr_addr] <= wr_val;
    end
    if (!stall) begin
      a_rd_r <= a_mem[a_addr];
      b_rd_r <= b_mem[b_addr];
    end
  end

  assign prod_ext = 64'(prod_r);
  assign acc_nxt  = (s2_tag_r.first ? '0 : acc_r) + prod_ext[PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (!stall) begin
      prod_r <= $signed(a_rd_r) * $signed(b_rd_r);
      if (s2_tag_r.valid) begin
        acc_r <= acc_nxt;
      end
      if (s2_tag_r.valid && s2_tag_r.last_k) begin
        out_row_r   <= s2_tag_r.row;
        out_col_r   <= s2_tag_r.col;
        out_value_r <= s2_tag_r.err ? '0 : acc_nxt;
        out_last_r  <= s2_tag_r.last_el;
        out_err_r   <= s2_tag_r.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      s1_tag_r    <= '0;
      s2_tag_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      if (!stall) begin
        s1_tag_r    <= issue_tag;
        s2_tag_r    <= s1_tag_r;
        out_valid_r <= s2_tag_r.valid && s2_tag_r.last_k;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.product_value = out_value_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.size_error    = out_err_r;

endmodule

@@ sv/matrix_multiply.sv @@
// Fixed-point matrix multiply C = A * B with Q8.8 elements and exact Q.16 sums.
// Load items write one element of A or B; a load outside the configured size
// and an unused command are dropped by the front end. A compute item yields
// a_rows*b_cols results in row-major order, the last one marked, or a single
// size_error result when a_cols and b_rows differ. The back end has one
// multiplier and issues one multiply-accumulate per cycle while the output is
// not stalled; a compute item takes a_rows*b_cols*a_cols of them. Each term
// passes the store read and product registers before the accumulator. A
// two-entry queue between front and back lets loads keep arriving while a
// result waits at the output. Element stores hold no reset value: read only
// elements that were loaded. Register i of the APB port is at byte address 4*i.
module matrix_multiply #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mm_in_if.sink                         in_ch,
  mm_out_if.source                      out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import mm_pkg::*;

  logic [DIM_W-1:0] a_rows_r;
  logic [DIM_W-1:0] a_cols_r;
  logic [DIM_W-1:0] b_rows_r;
  logic [DIM_W-1:0] b_cols_r;
  logic             cfg_wr;
  logic [1:0]       cfg_sel;
  dims_t            dims;

  logic q_push;
  op_t  q_push_op;
  logic q_push_ready;
  logic q_pop_valid;
  op_t  q_pop_op;
  logic q_pop;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] x);
    logic [DIM_W-1:0] res;
    res = x;
    if (x == '0) begin
      res = DIM_W'(1);
    end else if (x > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end
    return res;
  endfunction

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_RESET;
      a_cols_r <= DIM_RESET;
      b_rows_r <= DIM_RESET;
      b_cols_r <= DIM_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_A_ROWS: a_rows_r <= cfg_pwdata[DIM_W-1:0];
        REG_A_COLS: a_cols_r <= cfg_pwdata[DIM_W-1:0];
        REG_B_ROWS: b_rows_r <= cfg_pwdata[DIM_W-1:0];
        REG_B_COLS: b_cols_r <= cfg_pwdata[DIM_W-1:0];
        default: begin
          a_rows_r <= a_rows_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_A_ROWS: cfg_prdata = CFG_DATA_W'(a_rows_r);
      REG_A_COLS: cfg_prdata = CFG_DATA_W'(a_cols_r);
      REG_B_ROWS: cfg_prdata = CFG_DATA_W'(b_rows_r);
      REG_B_COLS: cfg_prdata = CFG_DATA_W'(b_cols_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign dims.ar = sat_dim(a_rows_r);
  assign dims.ac = sat_dim(a_cols_r);
  assign dims.br = sat_dim(b_rows_r);
  assign dims.bc = sat_dim(b_cols_r);

  mm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_ch      (in_ch),
    .dims       (dims),
    .push       (q_push),
    .push_op    (q_push_op),
    .push_ready (q_push_ready)
  );

  mm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_op     (q_pop_op),
    .pop        (q_pop)
  );

  mm_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .dims     (dims),
    .op_valid (q_pop_valid),
    .op       (q_pop_op),
    .op_pop   (q_pop),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // a size error item is a lone, final, all-zero result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.size_error |->
      out_ch.last && out_ch.product_value == '0 &&
      out_ch.out_row == '0 && out_ch.out_col == '0)
    else $error("size error result not final or not zero");

  // product coordinates stay inside the configured product size
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.size_error |->
      DIM_W'(out_ch.out_row) < dims.ar && DIM_W'(out_ch.out_col) < dims.bc)
    else $error("product coordinate outside configured size");

  // the final product element sits in the last row and column
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.size_error && out_ch.last |->
      DIM_W'(out_ch.out_row) == dims.ar - 1'b1 &&
      DIM_W'(out_ch.out_col) == dims.bc - 1'b1)
    else $error("last flag on a non-final product element");
`endif

endmodule
